[src/assert_macros.svh]
// assertion macros shared by the rtl
// expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/lpd_pkg.sv]
// types and constants for the length prefix deframer
// no dependencies
`timescale 1ns / 1ps

package lpd_pkg;

  localparam logic [7:0] SHORT_MAX_LEN = 8'd125;
  localparam logic [7:0] HDR_LEN16     = 8'd126;
  localparam logic [7:0] HDR_LEN32     = 8'd127;

  localparam logic [2:0] EXT_BYTES16   = 3'd2;
  localparam logic [2:0] EXT_BYTES32   = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_EXTLEN,
    PH_PAYLOAD,
    PH_ERROR
  } phase_e;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] frame_length;
    logic        frame_last;
    logic        frame_error;
  } res_t;

endpackage

[src/length_prefix_deframer_top.sv]
// length prefix deframer: byte stream in, payload beats with length and last mark (or an error mark) out
// depends on lpd_pkg and assert_macros.svh
//
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | data_byte_i
// out     | output    | out_valid_o / out_stall_i | payload_byte_o, frame_length_o,
//         |           |                        | frame_last_o, frame_error_o
//
// one beat per cycle unless in_stall_o is high: the parser state updates in the cycle a byte is taken
// a result is registered in the output register, or in the skid entry while out_stall_i holds the output
// output register plus one skid entry; in_stall_o rises only when the skid is full
// reset is asynchronous, active low; no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefix_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] frame_length_o,
  output logic        frame_last_o,
  output logic        frame_error_o
);
  import lpd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  ext_left_q, ext_left_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] pay_left_q, pay_left_d;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  res_t        out_q, out_d;
  res_t        skid_q, skid_d;

  logic        in_acc;
  logic        res_valid;
  res_t        res;
  logic [31:0] acc_shift;
  logic [2:0]  ext_dec;
  logic        last;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign acc_shift  = {len_acc_q[23:0], data_byte_i};
  assign ext_dec    = ext_left_q - 3'd1;
  assign last       = (pay_left_q <= 32'd1);

  // parser
  always_comb begin
    phase_d    = phase_q;
    ext_left_d = ext_left_q;
    len_acc_d  = len_acc_q;
    pay_left_d = pay_left_q;
    res_valid  = 1'b0;
    res        = '0;
    if (in_acc) begin
      case (phase_q)
        PH_HEADER: begin
          if (data_byte_i <= SHORT_MAX_LEN) begin
            if (data_byte_i != 8'd0) begin
              len_acc_d  = {24'd0, data_byte_i};
              pay_left_d = {24'd0, data_byte_i};
              phase_d    = PH_PAYLOAD;
            end
          end else if (data_byte_i == HDR_LEN16 || data_byte_i == HDR_LEN32) begin
            ext_left_d = (data_byte_i == HDR_LEN16) ? EXT_BYTES16 : EXT_BYTES32;
            len_acc_d  = '0;
            phase_d    = PH_EXTLEN;
          end else begin
            phase_d           = PH_ERROR;
            res_valid         = 1'b1;
            res.frame_error   = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_acc_d  = acc_shift;
          ext_left_d = ext_dec;
          if (ext_dec == 3'd0) begin
            if (acc_shift == 32'd0) begin
              phase_d = PH_HEADER;
            end else begin
              pay_left_d = acc_shift;
              phase_d    = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = data_byte_i;
          res.frame_length = len_acc_q;
          res.frame_last   = last;
          pay_left_d       = last ? 32'd0 : pay_left_q - 32'd1;
          if (last) begin
            phase_d = PH_HEADER;
          end
        end
        PH_ERROR: begin
          phase_d = PH_ERROR;
        end
        default: begin
          phase_d = PH_ERROR;
        end
      endcase
    end
  end

  // output register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_acc & res_valid;
        out_d       = res;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      ext_left_q   <= '0;
      len_acc_q    <= '0;
      pay_left_q   <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      ext_left_q   <= ext_left_d;
      len_acc_q    <= len_acc_d;
      pay_left_q   <= pay_left_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_q.payload_byte;
  assign frame_length_o = out_q.frame_length;
  assign frame_last_o   = out_q.frame_last;
  assign frame_error_o  = out_q.frame_error;

  `ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
  `ASSERT_NEXT(a_error_sticks, phase_q == PH_ERROR, phase_q == PH_ERROR)
  `ASSERT_IMPL(a_payload_left, phase_q == PH_PAYLOAD, pay_left_q != 32'd0)
  `ASSERT_IMPL(a_extlen_left, phase_q == PH_EXTLEN, ext_left_q != 3'd0)

endmodule
